// File: sv/tcf_pkg.sv
package tcf_pkg;

	// CORDIC iteration count and arctangent table length
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int USED_STEPS   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int STEP_W       = $clog2(TABLE_LEN + 1);

	// CORDIC datapath widths (x/y in Q4.12 << 8, angle in 1/65536 degree)
	localparam int XY_W  = 28;
	localparam int ANG_W = 28;
	localparam logic signed [ANG_W-1:0] HALF_TURN  = 28'sd11796480;
	localparam logic signed [ANG_W-1:0] ROUND_HALF = 28'sd128;
	localparam logic signed [ANG_W-1:0] TILT_MAX   = 28'sd46080;

	// square root widths
	localparam int SQ_W   = 48;
	localparam int ROOT_W = 24;

	// blend arithmetic
	localparam int FUSED_LIMIT = 92160;
	localparam int US_SCALE    = 62500;
	localparam int PROD_W      = 63;
	localparam int DEN_W       = 41;
	localparam int QUO_W       = 21;
	localparam int MUL_STEPS   = 24;
	localparam int CNT_W       = 5;

	// configuration register indexes
	localparam logic [0:0] REG_TAU    = 1'b0;
	localparam logic [0:0] REG_MAX_DT = 1'b1;

	typedef logic signed [17:0] fused_t;
	typedef logic signed [16:0] tilt_t;

	typedef struct packed {
		fused_t             prev;
		logic signed [15:0] rate;
		tilt_t              tilt;
		logic [19:0]        dt;
		logic [23:0]        tau;
	} blend_req_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ANG_W-1:0] arc_of(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] a;
		case (i)
			STEP_W'(0):  a = ANG_W'(2949120);
			STEP_W'(1):  a = ANG_W'(1740967);
			STEP_W'(2):  a = ANG_W'(919879);
			STEP_W'(3):  a = ANG_W'(466945);
			STEP_W'(4):  a = ANG_W'(234379);
			STEP_W'(5):  a = ANG_W'(117304);
			STEP_W'(6):  a = ANG_W'(58666);
			STEP_W'(7):  a = ANG_W'(29335);
			STEP_W'(8):  a = ANG_W'(14668);
			STEP_W'(9):  a = ANG_W'(7334);
			STEP_W'(10): a = ANG_W'(3667);
			STEP_W'(11): a = ANG_W'(1833);
			STEP_W'(12): a = ANG_W'(917);
			STEP_W'(13): a = ANG_W'(458);
			STEP_W'(14): a = ANG_W'(229);
			STEP_W'(15): a = ANG_W'(115);
			STEP_W'(16): a = ANG_W'(57);
			STEP_W'(17): a = ANG_W'(29);
			STEP_W'(18): a = ANG_W'(14);
			STEP_W'(19): a = ANG_W'(7);
			STEP_W'(20): a = ANG_W'(4);
			STEP_W'(21): a = ANG_W'(2);
			STEP_W'(22): a = ANG_W'(1);
			default:     a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: sv/tcf_isqrt.sv
module tcf_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tcf_pkg::SQ_W-1:0]   n_in,
	output logic [tcf_pkg::ROOT_W-1:0] root,
	output logic                       done
);
	import tcf_pkg::*;

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	// digit-by-digit root, two radicand bits a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (bit_q == SQ_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				rem_q  <= n_in;
				res_q  <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
			end else if (busy_q) begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == SQ_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

// File: sv/tcf_cordic.sv
module tcf_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [tcf_pkg::XY_W-1:0] y_in,
	input  logic signed [tcf_pkg::XY_W-1:0] x_in,
	output tcf_pkg::tilt_t                  angle,
	output logic                            done
);
	import tcf_pkg::*;

	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    fin_q;
	logic                    zero_q;
	logic                    done_q;
	tilt_t                   angle_q;

	logic signed [XY_W-1:0]  dx;
	logic signed [XY_W-1:0]  dy;
	logic signed [ANG_W-1:0] z_rnd;
	logic signed [ANG_W-1:0] z_sat;

	assign dx    = y_q >>> step_q;
	assign dy    = x_q >>> step_q;
	assign z_rnd = (z_q + ROUND_HALF) >>> 8;

	// final rounding and clamp to half a turn
	always_comb begin
		if (z_rnd > TILT_MAX)
			z_sat = TILT_MAX;
		else if (z_rnd < -TILT_MAX)
			z_sat = -TILT_MAX;
		else
			z_sat = z_rnd;
	end

	// vectoring iterations, one micro-rotation a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			zero_q  <= 1'b0;
			step_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			angle_q <= '0;
		end else begin
			done_q <= !start && !busy_q && fin_q;
			fin_q  <= !start && busy_q && (step_q == STEP_W'(USED_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				zero_q <= (x_in == '0) && (y_in == '0);
				// left half plane: rotate by half a turn first
				if (x_in < 0) begin
					x_q <= -x_in;
					y_q <= -y_in;
					z_q <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					z_q <= '0;
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + arc_of(step_q);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - arc_of(step_q);
				end
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(USED_STEPS - 1))
					busy_q <= 1'b0;
			end else if (fin_q) begin
				angle_q <= zero_q ? '0 : z_sat[16:0];
			end
		end
	end

	assign angle = angle_q;
	assign done  = done_q;

endmodule

// File: sv/tcf_blend.sv
module tcf_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tcf_pkg::blend_req_t req,
	output tcf_pkg::fused_t     q,
	output logic                done
);
	import tcf_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_PREP = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_MAG  = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;
	localparam logic [2:0] B_END  = 3'd5;

	localparam logic signed [17:0]      SCALE_S = 18'sd62500;
	localparam logic [15:0]             SCALE_U = 16'(US_SCALE);
	localparam logic signed [QUO_W:0]   Q_MAX   = (QUO_W + 1)'(FUSED_LIMIT);

	logic [2:0]               state_q;
	blend_req_t               req_q;
	logic signed [PROD_W-1:0] s_q;
	logic signed [PROD_W-1:0] t_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [DEN_W-1:0]         den_q;
	logic [23:0]              tau_sh_q;
	logic [19:0]              dt_sh_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        rem_q;
	logic [PROD_W-1:0]        dsh_q;
	logic [QUO_W-1:0]         quo_q;
	fused_t                   q_q;
	logic                     done_q;

	logic signed [PROD_W-1:0] s_v;
	logic signed [PROD_W-1:0] t_v;
	logic [DEN_W-1:0]         den_v;
	logic signed [PROD_W-1:0] add_s;
	logic signed [PROD_W-1:0] add_t;
	logic [PROD_W-1:0]        mag_v;
	logic signed [QUO_W:0]    qs_v;
	logic signed [QUO_W:0]    qc_v;

	// small products that feed the serial multiply
	assign s_v   = req_q.prev * SCALE_S + req_q.rate * $signed({1'b0, req_q.dt});
	assign t_v   = req_q.tilt * SCALE_S;
	assign den_v = ({1'b0, req_q.tau} + {5'b0, req_q.dt}) * SCALE_U;

	assign add_s = tau_sh_q[0] ? s_q : '0;
	assign add_t = dt_sh_q[0]  ? t_q : '0;

	// magnitude plus half divisor, for round half away from zero
	assign mag_v = (acc_q[PROD_W-1] ? PROD_W'(-acc_q) : PROD_W'(acc_q))
		+ PROD_W'(den_q >> 1);

	assign qs_v = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		if (qs_v > Q_MAX)
			qc_v = Q_MAX;
		else if (qs_v < -Q_MAX)
			qc_v = -Q_MAX;
		else
			qc_v = qs_v;
	end

	// sequencer: prepare, shift-add multiply, restoring divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			req_q    <= '0;
			s_q      <= '0;
			t_q      <= '0;
			acc_q    <= '0;
			den_q    <= '0;
			tau_sh_q <= '0;
			dt_sh_q  <= '0;
			neg_q    <= 1'b0;
			rem_q    <= '0;
			dsh_q    <= '0;
			quo_q    <= '0;
			q_q      <= '0;
		end else begin
			done_q <= (state_q == B_END);
			case (state_q)
				B_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					s_q      <= s_v;
					t_q      <= t_v;
					den_q    <= den_v;
					tau_sh_q <= req_q.tau;
					dt_sh_q  <= req_q.dt;
					acc_q    <= '0;
					cnt_q    <= '0;
					state_q  <= B_MUL;
				end
				B_MUL: begin
					acc_q    <= acc_q + add_s + add_t;
					s_q      <= s_q <<< 1;
					t_q      <= t_q <<< 1;
					tau_sh_q <= tau_sh_q >> 1;
					dt_sh_q  <= dt_sh_q >> 1;
					cnt_q    <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MUL_STEPS - 1))
						state_q <= B_MAG;
				end
				B_MAG: begin
					neg_q   <= acc_q[PROD_W-1];
					rem_q   <= mag_v;
					dsh_q   <= PROD_W'(den_q) << (QUO_W - 1);
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[QUO_W-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QUO_W-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUO_W - 1))
						state_q <= B_END;
				end
				B_END: begin
					q_q     <= qc_v[17:0];
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign q    = q_q;
	assign done = done_q;

endmodule

// File: sv/tilt_complementary_filter.sv
// Channel | Port group                  | Contents
// in      | s_tvalid/s_tready/s_tdata   | one IMU sample request, flags on s_tuser
// out     | m_tvalid/m_tready/m_tdata   | fused and tilt angles, status on m_tuser
// cfg     | cfg_we/cfg_index/cfg_data   | tau and maximum time step writes
//
// A sample passes through the square root (overlapped with the roll CORDIC),
// the pitch CORDIC, then two passes of the shared blend unit (shift-add
// multiply plus divide). A rejected or seeding sample skips the blend passes.
// s_tready is high only while no sample is in flight; a finished result waits
// in the output register, and the next sample may be taken meanwhile.
// Reset (arst_n) clears the fused state, the seeded flag and the other
// registers; tau and max_dt_q get their defaults instead.
module tilt_complementary_filter (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, step_us, zero pad
	input  logic [103:0] s_tdata,
	// sample_ok, calibrated
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fused_roll, fused_pitch, tilt_roll, tilt_pitch, zero pad
	output logic [71:0]  m_tdata,
	// result_valid, seeded
	output logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import tcf_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ROLL   = 3'd1;
	localparam logic [2:0] ST_PITCH  = 3'd2;
	localparam logic [2:0] ST_BROLL  = 3'd3;
	localparam logic [2:0] ST_BPITCH = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]             state_q;
	logic [23:0]            tau_q;
	logic [19:0]            max_dt_q;
	fused_t                 roll_q;
	fused_t                 pitch_q;
	logic                   seeded_q;
	logic                   ok_q;
	logic signed [XY_W-1:0] pitch_y_q;
	logic signed [15:0]     rx_q;
	logic signed [15:0]     ry_q;
	logic [19:0]            dt_q;
	tilt_t                  tilt_r_q;
	tilt_t                  tilt_p_q;
	logic                   have_roll_q;
	logic                   have_root_q;
	fused_t                 new_roll_q;
	fused_t                 new_pitch_q;
	logic                   m_tvalid_q;
	logic [71:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	// input field views
	logic signed [15:0]     ax;
	logic signed [15:0]     ay;
	logic signed [15:0]     az;
	logic [19:0]            step;
	logic                   take;
	logic                   ok_v;
	logic signed [32:0]     sq_v;
	logic signed [XY_W-1:0] ax_w;
	logic signed [XY_W-1:0] ay_w;
	logic signed [XY_W-1:0] az_w;

	logic                   cor_start;
	logic signed [XY_W-1:0] cor_y;
	logic signed [XY_W-1:0] cor_x;
	tilt_t                  cor_angle;
	logic                   cor_done;
	logic [ROOT_W-1:0]      root;
	logic                   sq_done;
	logic                   roll_in;
	logic                   root_in;
	logic                   pitch_go;
	logic                   bl_start;
	blend_req_t             bl_req;
	fused_t                 bl_q;
	logic                   bl_done;
	logic                   out_free;
	fused_t                 fr_v;
	fused_t                 fp_v;

	assign ax   = s_tdata[15:0];
	assign ay   = s_tdata[31:16];
	assign az   = s_tdata[47:32];
	assign step = s_tdata[99:80];
	assign ax_w = XY_W'(ax);
	assign ay_w = XY_W'(ay);
	assign az_w = XY_W'(az);

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign ok_v     = s_tuser[0] && s_tuser[1] && (step != '0) && (step <= max_dt_q)
		&& (tau_q != '0);
	assign sq_v     = 33'(ay) * 33'(ay) + 33'(az) * 33'(az);

	// square root runs alongside the roll angle
	tcf_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (take),
		.n_in  ({sq_v[31:0], 16'b0}),
		.root  (root),
		.done  (sq_done)
	);

	// roll uses the CORDIC first, pitch once the root is ready
	assign roll_in  = have_roll_q || cor_done;
	assign root_in  = have_root_q || sq_done;
	assign pitch_go = (state_q == ST_ROLL) && roll_in && root_in;
	assign cor_start = take || pitch_go;
	assign cor_y = (state_q == ST_IDLE) ? (ay_w <<< 8) : pitch_y_q;
	assign cor_x = (state_q == ST_IDLE) ? (az_w <<< 8)
		: $signed({{(XY_W - ROOT_W){1'b0}}, root});

	tcf_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start),
		.y_in  (cor_y),
		.x_in  (cor_x),
		.angle (cor_angle),
		.done  (cor_done)
	);

	// blend unit serves roll then pitch
	assign bl_start = ((state_q == ST_PITCH) && cor_done && ok_q && seeded_q)
		|| ((state_q == ST_BROLL) && bl_done);

	always_comb begin
		bl_req.dt  = dt_q;
		bl_req.tau = tau_q;
		if (state_q == ST_BROLL) begin
			bl_req.prev = pitch_q;
			bl_req.rate = ry_q;
			bl_req.tilt = tilt_p_q;
		end else begin
			bl_req.prev = roll_q;
			bl_req.rate = rx_q;
			bl_req.tilt = tilt_r_q;
		end
	end

	tcf_blend u_blend (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bl_start),
		.req   (bl_req),
		.q     (bl_q),
		.done  (bl_done)
	);

	// next fused state
	assign out_free = !m_tvalid_q || m_tready;
	assign fr_v = !ok_q ? roll_q  : (seeded_q ? new_roll_q  : fused_t'(tilt_r_q));
	assign fp_v = !ok_q ? pitch_q : (seeded_q ? new_pitch_q : fused_t'(tilt_p_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q    <= 24'd500000;
			max_dt_q <= 20'd100000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAU:    tau_q    <= cfg_data;
				REG_MAX_DT: max_dt_q <= cfg_data[19:0];
				default:    ;
			endcase
		end
	end

	// sample sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			roll_q      <= '0;
			pitch_q     <= '0;
			seeded_q    <= 1'b0;
			ok_q        <= 1'b0;
			pitch_y_q   <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			dt_q        <= '0;
			tilt_r_q    <= '0;
			tilt_p_q    <= '0;
			have_roll_q <= 1'b0;
			have_root_q <= 1'b0;
			new_roll_q  <= '0;
			new_pitch_q <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			// result held until taken, reloaded when a sample finishes
			m_tvalid_q <= ((state_q == ST_OUT) && out_free) || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						ok_q        <= ok_v;
						pitch_y_q   <= -(ax_w <<< 8);
						rx_q        <= s_tdata[63:48];
						ry_q        <= s_tdata[79:64];
						dt_q        <= step;
						have_roll_q <= 1'b0;
						have_root_q <= 1'b0;
						state_q     <= ST_ROLL;
					end
				end
				ST_ROLL: begin
					if (cor_done)
						tilt_r_q <= cor_angle;
					have_roll_q <= roll_in;
					have_root_q <= root_in;
					if (pitch_go)
						state_q <= ST_PITCH;
				end
				ST_PITCH: begin
					if (cor_done) begin
						tilt_p_q <= cor_angle;
						state_q  <= (ok_q && seeded_q) ? ST_BROLL : ST_OUT;
					end
				end
				ST_BROLL: begin
					if (bl_done) begin
						new_roll_q <= bl_q;
						state_q    <= ST_BPITCH;
					end
				end
				ST_BPITCH: begin
					if (bl_done) begin
						new_pitch_q <= bl_q;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						roll_q     <= fr_v;
						pitch_q    <= fp_v;
						seeded_q   <= seeded_q || ok_q;
						m_tdata_q  <= {2'b0, tilt_p_q, tilt_r_q, fp_v, fr_v};
						m_tuser_q  <= {seeded_q || ok_q, ok_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	// a valid result flagged result_valid always reports a seeded filter
	a_valid_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("result valid without seeded flag");

	// fused roll stays within its saturation limit
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[17:0]) <= 18'sd92160
			&& $signed(m_tdata[17:0]) >= -18'sd92160))
		else $error("fused roll out of range");

	// one sample at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// once seeded, the filter stays seeded
	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag dropped");
`endif

endmodule
